// ===== design/lob_pkg.sv =====
// lob_pkg: shared types and codes of the limit order book matcher.
// Used by lob_front, lob_queue, lob_back and limit_order_book_matcher.
`timescale 1ns / 1ps
package lob_pkg;

  localparam int unsigned ORDER_SLOTS_DEF = 32;
  localparam int unsigned PRICE_TICKS_DEF = 1024;
  localparam int unsigned PRICE_W         = 10;
  localparam int unsigned QTY_W           = 32;
  localparam int unsigned ID_W            = 32;
  localparam int unsigned QUEUE_DEPTH     = 2;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;
  localparam logic SIDE_BUY   = 1'b0;
  localparam logic SIDE_SELL  = 1'b1;

  typedef enum logic [2:0] {
    KIND_TRADE      = 3'd0,
    KIND_DONE       = 3'd1,
    KIND_RESTED     = 3'd2,
    KIND_POOL_FULL  = 3'd3,
    KIND_CANCELLED  = 3'd4,
    KIND_NOT_FOUND  = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_FILL,
    ST_REST,
    ST_CANCEL
  } back_state_t;

  typedef struct packed {
    logic               req_type;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [QTY_W-1:0]   qty;
    logic [ID_W-1:0]    id;
  } req_t;

endpackage

// ===== design/lob_front.sv =====
// lob_front: accepts request transactions and clamps add limit prices.
// Depends on lob_pkg; feeds lob_queue.
`timescale 1ns / 1ps
module lob_front #(
  parameter int unsigned PRICE_TICKS = lob_pkg::PRICE_TICKS_DEF
) (
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic                        in_side,
  input  logic [lob_pkg::PRICE_W-1:0] in_limit_price,
  input  logic [lob_pkg::QTY_W-1:0]   in_order_qty,
  input  logic [lob_pkg::ID_W-1:0]    in_order_id,
  input  logic                        q_full,
  output logic                        q_push,
  output lob_pkg::req_t               q_data
);
  import lob_pkg::*;

  localparam int unsigned PRICE_LIM =
    (PRICE_TICKS > (1 << PRICE_W)) ? ((1 << PRICE_W) - 1) : (PRICE_TICKS - 1);

  logic [PRICE_W-1:0] price_sat;

  assign price_sat = (32'(in_limit_price) > PRICE_LIM) ? PRICE_W'(PRICE_LIM) : in_limit_price;

  assign in_stall = q_full;
  assign q_push   = in_valid & ~q_full;

  always_comb begin
    q_data.req_type = in_req_type;
    q_data.side     = in_side;
    q_data.price    = (in_req_type == REQ_ADD) ? price_sat : in_limit_price;
    q_data.qty      = in_order_qty;
    q_data.id       = in_order_id;
  end

endmodule

// ===== design/lob_queue.sv =====
// lob_queue: short request queue between the front and the back.
// Depends on lob_pkg for the request type and depth.
`timescale 1ns / 1ps
module lob_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  lob_pkg::req_t push_data,
  output logic          full,
  input  logic          pop,
  output lob_pkg::req_t pop_data,
  output logic          empty
);
  import lob_pkg::*;

  localparam int unsigned QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  req_t           mem_r [QUEUE_DEPTH];
  logic [QW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QW:0]    cnt_r;

  assign full     = (cnt_r == (QW+1)'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== design/lob_back.sv =====
// lob_back: order pool, priority matrix and matching sequencer with output register.
// Depends on lob_pkg; takes requests from lob_queue.
`timescale 1ns / 1ps
module lob_back #(
  parameter int unsigned ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_empty,
  input  lob_pkg::req_t               q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic [lob_pkg::QTY_W-1:0]   out_fill_qty,
  output logic [lob_pkg::PRICE_W-1:0] out_fill_price,
  output logic [lob_pkg::ID_W-1:0]    out_buyer_id,
  output logic [lob_pkg::ID_W-1:0]    out_seller_id,
  output logic [lob_pkg::ID_W-1:0]    out_request_id,
  output logic                        out_last
);
  import lob_pkg::*;

  localparam int unsigned SW = $clog2(ORDER_SLOTS);

  back_state_t state_r, state_nxt;

  // current request
  logic               side_r;
  logic [PRICE_W-1:0] lim_r;
  logic [QTY_W-1:0]   rem_r;
  logic [ID_W-1:0]    id_r;
  logic [SW-1:0]      win_r;

  // order pool; prio_r[i][j] set when slot i goes ahead of slot j
  logic [ORDER_SLOTS-1:0] used_r;
  logic [ID_W-1:0]        slot_id_r    [ORDER_SLOTS];
  logic [QTY_W-1:0]       slot_qty_r   [ORDER_SLOTS];
  logic [PRICE_W-1:0]     slot_price_r [ORDER_SLOTS];
  logic                   slot_side_r  [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] prio_r       [ORDER_SLOTS];

  logic               out_valid_r;
  kind_t              out_kind_r;
  logic [QTY_W-1:0]   out_qty_r;
  logic [PRICE_W-1:0] out_price_r;
  logic [ID_W-1:0]    out_buyer_r, out_seller_r, out_req_r;
  logic               out_last_r;

  logic [ORDER_SLOTS-1:0] cand, win_hot, beats;
  logic                   found, free_found, hit_found;
  logic [SW-1:0]          win_idx, free_idx, hit_idx;
  logic [QTY_W-1:0]       wq, fq;
  logic                   out_free;

  logic               emit, do_sel, do_fill, do_rest, do_cancel;
  kind_t              e_kind;
  logic [QTY_W-1:0]   e_qty;
  logic [PRICE_W-1:0] e_price;
  logic [ID_W-1:0]    e_buyer, e_seller;
  logic               e_last;

  // crossing resting orders of the other side, and the one with top priority
  always_comb begin
    logic hit_any;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      cand[i] = used_r[i] && (slot_side_r[i] != side_r) &&
                ((side_r == SIDE_BUY) ? (slot_price_r[i] <= lim_r)
                                      : (slot_price_r[i] >= lim_r));
      beats[i] = (side_r == SIDE_SELL) ? (lim_r < slot_price_r[i])
                                       : (lim_r > slot_price_r[i]);
    end
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      hit_any = 1'b0;
      for (int j = 0; j < ORDER_SLOTS; j++) begin
        hit_any = hit_any | (cand[j] & prio_r[j][i] & (j != i));
      end
      win_hot[i] = cand[i] & ~hit_any;
    end
    found   = |win_hot;
    win_idx = '0;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (win_hot[i]) win_idx = SW'(i);
    end
  end

  // lowest free slot and lowest slot holding the cancel id
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    hit_found  = 1'b0;
    hit_idx    = '0;
    for (int i = ORDER_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
      if (used_r[i] && (slot_id_r[i] == id_r)) begin
        hit_found = 1'b1;
        hit_idx   = SW'(i);
      end
    end
  end

  assign wq       = slot_qty_r[win_r];
  assign fq       = (rem_r < wq) ? rem_r : wq;
  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    do_sel    = 1'b0;
    do_fill   = 1'b0;
    do_rest   = 1'b0;
    do_cancel = 1'b0;
    e_kind    = KIND_DONE;
    e_qty     = '0;
    e_price   = lim_r;
    e_buyer   = '0;
    e_seller  = '0;
    e_last    = 1'b1;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = (q_data.req_type == REQ_CANCEL) ? ST_CANCEL : ST_SEL;
        end
      end
      ST_SEL: begin
        if (rem_r == '0) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          do_sel    = 1'b1;
          state_nxt = found ? ST_FILL : ST_REST;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          emit      = 1'b1;
          do_fill   = 1'b1;
          e_kind    = KIND_TRADE;
          e_qty     = fq;
          e_price   = slot_price_r[win_r];
          e_buyer   = (side_r == SIDE_BUY) ? id_r : slot_id_r[win_r];
          e_seller  = (side_r == SIDE_BUY) ? slot_id_r[win_r] : id_r;
          e_last    = 1'b0;
          state_nxt = ST_SEL;
        end
      end
      ST_REST: begin
        if (out_free) begin
          emit      = 1'b1;
          do_rest   = free_found;
          e_kind    = free_found ? KIND_RESTED : KIND_POOL_FULL;
          e_qty     = rem_r;
          state_nxt = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        if (out_free) begin
          emit      = 1'b1;
          do_cancel = hit_found;
          if (hit_found) begin
            e_kind  = KIND_CANCELLED;
            e_qty   = slot_qty_r[hit_idx];
            e_price = slot_price_r[hit_idx];
          end else begin
            e_kind  = KIND_NOT_FOUND;
            e_price = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      used_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit | (out_valid_r & out_stall);
      if (do_fill && (wq == fq)) used_r[win_r]    <= 1'b0;
      if (do_rest)               used_r[free_idx] <= 1'b1;
      if (do_cancel)             used_r[hit_idx]  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      side_r <= q_data.side;
      lim_r  <= q_data.price;
      rem_r  <= q_data.qty;
      id_r   <= q_data.id;
    end else if (do_fill) begin
      rem_r  <= rem_r - fq;
    end
    if (do_sel) win_r <= win_idx;
    if (do_fill) slot_qty_r[win_r] <= wq - fq;
    if (do_rest) begin
      slot_id_r[free_idx]    <= id_r;
      slot_qty_r[free_idx]   <= rem_r;
      slot_price_r[free_idx] <= lim_r;
      slot_side_r[free_idx]  <= side_r;
      // a new order goes behind equal prices already resting
      for (int j = 0; j < ORDER_SLOTS; j++) begin
        if (j == int'(free_idx)) begin
          prio_r[j][j] <= 1'b0;
        end else begin
          prio_r[free_idx][j] <= beats[j];
          prio_r[j][free_idx] <= ~beats[j];
        end
      end
    end
    if (emit) begin
      out_kind_r   <= e_kind;
      out_qty_r    <= e_qty;
      out_price_r  <= e_price;
      out_buyer_r  <= e_buyer;
      out_seller_r <= e_seller;
      out_req_r    <= id_r;
      out_last_r   <= e_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_fill_qty   = out_qty_r;
  assign out_fill_price = out_price_r;
  assign out_buyer_id   = out_buyer_r;
  assign out_seller_id  = out_seller_r;
  assign out_request_id = out_req_r;
  assign out_last       = out_last_r;

endmodule

// ===== design/limit_order_book_matcher.sv =====
// Price-time priority limit order book: an add or cancel request enters per transaction
// and yields its trades followed by one status item with out_last set. Requests pass a
// two-entry queue to a back-end sequencer that handles one request at a time: a cancel
// emits one status; an add selects and fills per trade, then rests or rejects (zero
// quantity: status only). Each fill is one priority select over the resting pool
// followed by one update, so the trade count sets the time. Up to ORDER_SLOTS orders
// rest; within a price older orders fill first. No clearing pass is needed after reset.
// Depends on lob_pkg, lob_front, lob_queue and lob_back.
`timescale 1ns / 1ps
module limit_order_book_matcher #(
  parameter int unsigned ORDER_SLOTS = lob_pkg::ORDER_SLOTS_DEF,
  parameter int unsigned PRICE_TICKS = lob_pkg::PRICE_TICKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_req_type,
  input  logic                        in_side,
  input  logic [lob_pkg::PRICE_W-1:0] in_limit_price,
  input  logic [lob_pkg::QTY_W-1:0]   in_order_qty,
  input  logic [lob_pkg::ID_W-1:0]    in_order_id,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2:0]                  out_kind,
  output logic [lob_pkg::QTY_W-1:0]   out_fill_qty,
  output logic [lob_pkg::PRICE_W-1:0] out_fill_price,
  output logic [lob_pkg::ID_W-1:0]    out_buyer_id,
  output logic [lob_pkg::ID_W-1:0]    out_seller_id,
  output logic [lob_pkg::ID_W-1:0]    out_request_id,
  output logic                        out_last
);
  import lob_pkg::*;

  logic q_full, q_push, q_pop, q_empty;
  req_t push_data, pop_data;

  lob_front #(.PRICE_TICKS(PRICE_TICKS)) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_side       (in_side),
    .in_limit_price(in_limit_price),
    .in_order_qty  (in_order_qty),
    .in_order_id   (in_order_id),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_data        (push_data)
  );

  lob_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (pop_data),
    .empty    (q_empty)
  );

  lob_back #(.ORDER_SLOTS(ORDER_SLOTS)) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_data        (pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_fill_qty  (out_fill_qty),
    .out_fill_price(out_fill_price),
    .out_buyer_id  (out_buyer_id),
    .out_seller_id (out_seller_id),
    .out_request_id(out_request_id),
    .out_last      (out_last)
  );

endmodule
